/* src/bsed_pkg.sv */
// Shared types and constants for the backslash escape decoder.
package bsed_pkg;

	localparam logic [7:0] BSLASH = 8'h5C;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
	} entry_t;

	// Results written into the queue by one accepted input byte (0, 1 or 2).
	typedef struct packed {
		logic [1:0] n;
		entry_t     e0;
		entry_t     e1;
	} push_t;

endpackage

/* src/backslash_escape_decoder.sv */
// Top level of the backslash escape decoder.
// Decodes backslash quoting, one input byte per cycle while in_ready is high. A result is
// written into the queue, then loaded into the output register, and only then shows on the
// output. Most bytes give zero or one result; an unknown escape gives two, and so does
// a byte that ends an octal run unless it is a backslash that opens a new escape mid-string.
// The back end sends the two one after the other. Input ready follows the free space of
// the QDEPTH-entry queue between front and back (at least two slots free; QDEPTH is a power
// of two, at least 2), so with a ready sink one byte per cycle is sustained. out_last and
// out_bad_escape mark the final result of each string.
module backslash_escape_decoder #(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_bad_escape
);

	bsed_pkg::push_t  push;
	bsed_pkg::entry_t q_head;
	logic             room;
	logic             q_valid;
	logic             pop;

	bsed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.room     (room),
		.push     (push)
	);

	bsed_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (pop)
	);

	bsed_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.out_last       (out_last),
		.out_bad_escape (out_bad_escape)
	);

endmodule

/* src/bsed_front.sv */
// Front end: accepts raw bytes, tracks escape state, pushes decoded results.
module bsed_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic                 room,
	output bsed_pkg::push_t      push
);

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ESC   = 2'd1,
		PH_OCT1  = 2'd2,
		PH_OCT2  = 2'd3
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [5:0] accum_q, accum_n;
	logic       err_q, err_n;
	logic       accept;
	logic       is_oct;
	logic [2:0] digit;
	logic [1:0] cnt;
	logic [7:0] res0, res1;
	logic [8:0] known;

	// Simple escape characters; bit 8 marks a hit.
	function automatic logic [8:0] simple_escape(input logic [7:0] b);
		logic [8:0] r;
		case (b)
			8'h5C:   r = {1'b1, bsed_pkg::BSLASH};
			8'h6E:   r = {1'b1, 8'h0A};
			8'h74:   r = {1'b1, 8'h09};
			8'h66:   r = {1'b1, 8'h0C};
			8'h62:   r = {1'b1, 8'h08};
			8'h72:   r = {1'b1, 8'h0D};
			8'h3F:   r = {1'b1, 8'h7F};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	assign in_ready = room;
	assign accept   = in_valid && in_ready;
	assign is_oct   = (in_byte[7:3] == 5'b00110);
	assign digit    = in_byte[2:0];
	assign known    = simple_escape(in_byte);

	always_comb begin
		phase_n = phase_q;
		accum_n = accum_q;
		err_n   = err_q;
		cnt     = 2'd0;
		res0    = in_byte;
		res1    = in_byte;
		case (phase_q)
			PH_PLAIN: begin
				if (in_byte == bsed_pkg::BSLASH) begin
					phase_n = PH_ESC;
					if (in_last) begin
						cnt   = 2'd1;
						res0  = bsed_pkg::BSLASH;
						err_n = 1'b1;
					end
				end else begin
					cnt = 2'd1;
				end
			end
			PH_ESC: begin
				phase_n = PH_PLAIN;
				if (known[8]) begin
					cnt  = 2'd1;
					res0 = known[7:0];
				end else if (is_oct) begin
					accum_n = {3'b000, digit};
					phase_n = PH_OCT1;
					if (in_last) begin
						cnt  = 2'd1;
						res0 = {5'b00000, digit};
					end
				end else begin
					err_n = 1'b1;
					cnt   = 2'd2;
					res0  = bsed_pkg::BSLASH;
				end
			end
			default: begin
				if (is_oct) begin
					if (phase_q == PH_OCT1) begin
						accum_n = {accum_q[2:0], digit};
						phase_n = PH_OCT2;
						if (in_last) begin
							cnt  = 2'd1;
							res0 = {2'b00, accum_q[2:0], digit};
						end
					end else begin
						phase_n = PH_PLAIN;
						cnt     = 2'd1;
						res0    = {accum_q[4:0], digit};
					end
				end else begin
					// Octal run ends; the terminating byte is decoded as plain text.
					res0 = {2'b00, accum_q};
					if (in_byte == bsed_pkg::BSLASH) begin
						phase_n = PH_ESC;
						if (in_last) begin
							cnt   = 2'd2;
							res1  = bsed_pkg::BSLASH;
							err_n = 1'b1;
						end else begin
							cnt = 2'd1;
						end
					end else begin
						phase_n = PH_PLAIN;
						cnt     = 2'd2;
					end
				end
			end
		endcase
		if (phase_n == PH_PLAIN) begin
			accum_n = 6'd0;
		end
	end

	always_comb begin
		push.n       = accept ? cnt : 2'd0;
		push.e0.data = res0;
		push.e0.last = in_last && (cnt == 2'd1);
		push.e0.bad  = in_last && (cnt == 2'd1) && err_n;
		push.e1.data = res1;
		push.e1.last = in_last;
		push.e1.bad  = in_last && err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			accum_q <= 6'd0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				phase_q <= PH_PLAIN;
				accum_q <= 6'd0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				accum_q <= accum_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

/* src/bsed_queue.sv */
// Small queue between front and back: up to two writes and one read per cycle.
module bsed_queue #(
	parameter int QDEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsed_pkg::push_t      push,
	output logic                 room,
	output logic                 q_valid,
	output bsed_pkg::entry_t     q_head,
	input  logic                 pop
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	bsed_pkg::entry_t mem_q [QDEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign room    = (count_q <= CW'(QDEPTH - 2));
	assign q_valid = (count_q != '0);
	assign q_head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.e0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule

/* src/bsed_back.sv */
// Back end: output register; drains the queue one result per ready cycle.
module bsed_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  bsed_pkg::entry_t     q_head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	output logic                 out_bad_escape
);

	logic             out_valid_q;
	bsed_pkg::entry_t out_q;

	assign pop            = q_valid && (!out_valid_q || out_ready);
	assign out_valid      = out_valid_q;
	assign out_byte       = out_q.data;
	assign out_last       = out_q.last;
	assign out_bad_escape = out_q.bad;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* src/bsed_checker.sv */
// Port-level checks for the backslash escape decoder, bound to the top level.
module bsed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       out_bad_escape
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
			&& $stable(out_bad_escape))
		else $error("output transfer dropped or changed while stalled");

	a_bad_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bad_escape |-> out_last)
		else $error("error flag on a result that is not the final one");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_last_then_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |-> !out_bad_escape)
		else $error("error flag on inner result");

endmodule

bind backslash_escape_decoder bsed_checker u_bsed_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.out_byte       (out_byte),
	.out_last       (out_last),
	.out_bad_escape (out_bad_escape)
);

/* verif/tb_backslash_escape_decoder.sv */
// Testbench for the backslash escape decoder: decode predictor, scoreboard and top module.
package escape_decode_tb_pkg;

	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_SEVEN = "7";
	localparam logic [7:0] CH_N     = "n";
	localparam logic [7:0] CH_T     = "t";
	localparam logic [7:0] CH_F     = "f";
	localparam logic [7:0] CH_B     = "b";
	localparam logic [7:0] CH_R     = "r";
	localparam logic [7:0] CH_QMARK = "?";
	localparam logic [7:0] CTL_LF   = 8'h0A;
	localparam logic [7:0] CTL_TAB  = 8'h09;
	localparam logic [7:0] CTL_FF   = 8'h0C;
	localparam logic [7:0] CTL_BS   = 8'h08;
	localparam logic [7:0] CTL_CR   = 8'h0D;
	localparam logic [7:0] CTL_DEL  = 8'h7F;

	typedef enum logic [1:0] {
		PH_TEXT,
		PH_ESC,
		PH_OCT1,
		PH_OCT2
	} decode_phase_t;

	class escape_scoreboard;
		bsed_pkg::entry_t decoded_q[$];
		decode_phase_t    phase;
		logic [5:0]       octal_val;
		logic             err_flag;
		int unsigned      fails;

		function new();
			phase = PH_TEXT;
			octal_val = '0;
			err_flag = 1'b0;
			fails = 0;
		endfunction

		function int unsigned pending();
			return decoded_q.size();
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= CH_ZERO && b <= CH_SEVEN;
		endfunction

		function void push_byte(logic [7:0] v);
			bsed_pkg::entry_t e;
			e.data = v;
			e.last = 1'b0;
			e.bad = 1'b0;
			decoded_q.push_back(e);
		endfunction

		function void text_byte(logic [7:0] b, logic last);
			if (b == bsed_pkg::BSLASH) begin
				if (last) begin
					err_flag = 1'b1;
					push_byte(bsed_pkg::BSLASH);
				end
				phase = PH_ESC;
			end else begin
				push_byte(b);
				phase = PH_TEXT;
			end
		endfunction

		// Decode one accepted input transfer into the results it causes.
		function void note_input(logic [7:0] b, logic last);
			int unsigned n_prior;
			bsed_pkg::entry_t e;
			n_prior = decoded_q.size();
			case (phase)
				PH_TEXT: text_byte(b, last);
				PH_ESC: begin
					phase = PH_TEXT;
					case (b)
						bsed_pkg::BSLASH: push_byte(bsed_pkg::BSLASH);
						CH_N:     push_byte(CTL_LF);
						CH_T:     push_byte(CTL_TAB);
						CH_F:     push_byte(CTL_FF);
						CH_B:     push_byte(CTL_BS);
						CH_R:     push_byte(CTL_CR);
						CH_QMARK: push_byte(CTL_DEL);
						default: begin
							if (is_digit(b)) begin
								octal_val = {3'b000, b[2:0]};
								phase = PH_OCT1;
								if (last)
									push_byte({2'b00, octal_val});
							end else begin
								err_flag = 1'b1;
								push_byte(bsed_pkg::BSLASH);
								push_byte(b);
							end
						end
					endcase
				end
				PH_OCT1: begin
					if (is_digit(b)) begin
						octal_val = {octal_val[2:0], b[2:0]};
						phase = PH_OCT2;
						if (last)
							push_byte({2'b00, octal_val});
					end else begin
						push_byte({2'b00, octal_val});
						text_byte(b, last);
					end
				end
				default: begin
					if (is_digit(b)) begin
						// three digits wrap to 8 bits
						push_byte({octal_val[4:0], b[2:0]});
						phase = PH_TEXT;
					end else begin
						push_byte({2'b00, octal_val});
						text_byte(b, last);
					end
				end
			endcase
			if (phase == PH_TEXT)
				octal_val = '0;
			if (last) begin
				if (decoded_q.size() > n_prior) begin
					e = decoded_q.pop_back();
					e.last = 1'b1;
					e.bad = err_flag;
					decoded_q.push_back(e);
				end
				phase = PH_TEXT;
				octal_val = '0;
				err_flag = 1'b0;
			end
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			fails++;
		endtask

		task check_result(logic [7:0] data, logic last, logic bad);
			bsed_pkg::entry_t e;
			if (decoded_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %02h", data));
			end else begin
				e = decoded_q.pop_front();
				if (data !== e.data)
					report_mismatch($sformatf("out_byte %02h, want %02h", data, e.data));
				if (last !== e.last)
					report_mismatch($sformatf("out_last %b, want %b (byte %02h)",
						last, e.last, e.data));
				if (bad !== e.bad)
					report_mismatch($sformatf("out_bad_escape %b, want %b (byte %02h)",
						bad, e.bad, e.data));
			end
		endtask
	endclass

endpackage

module tb_backslash_escape_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_bad_escape;

	escape_decode_tb_pkg::escape_scoreboard sb;
	int unsigned      sent_n;
	bit               send_calm;
	bit               recv_calm;

	backslash_escape_decoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.in_last        (in_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.out_last       (out_last),
		.out_bad_escape (out_bad_escape)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function logic [7:0] rand_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 8'($urandom_range(0, 255));
		if (r < 60)
			return bsed_pkg::BSLASH;
		if (r < 82)
			return escape_decode_tb_pkg::CH_ZERO + 8'($urandom_range(0, 7));
		case ($urandom_range(0, 6))
			0: return escape_decode_tb_pkg::CH_N;
			1: return escape_decode_tb_pkg::CH_T;
			2: return escape_decode_tb_pkg::CH_F;
			3: return escape_decode_tb_pkg::CH_B;
			4: return escape_decode_tb_pkg::CH_R;
			5: return escape_decode_tb_pkg::CH_QMARK;
			default: return bsed_pkg::BSLASH;
		endcase
	endfunction

	task send_item(logic [7:0] b, logic last);
		int unsigned gap;
		gap = pick_gap(send_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(b, last);
		sent_n++;
	endtask

	task send_text(string s, logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], last_at_end && (i == s.len() - 1));
	endtask

	// hold the sender off until every decoded byte is out
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int unsigned stall_n;
		int unsigned cycle_n;
		stall_n = 0;
		cycle_n = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_byte, out_last, out_bad_escape);
			cycle_n++;
			if (cycle_n % 300 == 0)
				recv_calm = ($urandom_range(0, 3) == 0);
			if (stall_n != 0) begin
				stall_n--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_n = pick_gap(recv_calm);
			end
		end
	end

	initial begin
		int unsigned len;
		int unsigned str_n;
		sb = new();
		sent_n = 0;
		str_n = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= '0;
		in_last <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h00, 1'b0);
		send_text("\\n\\t\\f\\b\\r\\?\\\\", 1'b1);
		send_item(8'hFF, 1'b0);
		send_text("\\777\\4x\\12\\", 1'b0);
		send_item(8'h00, 1'b0);
		send_item(bsed_pkg::BSLASH, 1'b1);
		send_text("\\5", 1'b1);
		send_text("\\12", 1'b1);
		drain();

		while (sent_n < 740) begin
			send_calm = ($urandom_range(0, 4) == 0);
			len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
			for (int i = 0; i < len; i++)
				send_item(rand_char(), i == len - 1);
			str_n++;
			if (str_n == 40)
				drain();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
src/bsed_pkg.sv
src/bsed_front.sv
src/bsed_queue.sv
src/bsed_back.sv
src/backslash_escape_decoder.sv
src/bsed_checker.sv
verif/tb_backslash_escape_decoder.sv
